// File: rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants, codes and types of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

   // Pattern geometry
   localparam int PATTERN_MAX    = 32;
   localparam int WORD_COUNT     = 4;
   localparam int WORD_W         = 64;
   localparam int BYTE_W         = 8;
   localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
   localparam int PAT_BYTES      = WORD_COUNT * BYTES_PER_WORD;
   localparam int LENGTH_W       = 6;
   localparam int POS_W          = $clog2(PATTERN_MAX + 1);
   localparam int PREFIX_LEVELS  = $clog2(PATTERN_MAX + 1);

   // Register port
   localparam int CSR_IDX_W = $clog2(WORD_COUNT + 1);

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Special pattern bytes
   localparam logic [BYTE_W-1:0] STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] QMARK = 8'h3F;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WORD_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WORD_1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_WORD_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_WORD_3 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH = CSR_IDX_W'(4);

   // Active set right after reset or end of text: start position only
   localparam logic [PATTERN_MAX:0] START_SET = (PATTERN_MAX + 1)'(1);

   typedef enum logic [0:0] {
      FUNC_BYTE = 1'b0,
      FUNC_END  = 1'b1
   } func_type;

   // One queued request
   typedef struct packed {
      func_type          func;
      logic [BYTE_W-1:0] text;
   } op_type;

   // Decoded pattern handed to the back end
   typedef struct packed {
      logic [PATTERN_MAX-1:0]             star;
      logic [PATTERN_MAX-1:0]             qmark;
      logic [PATTERN_MAX-1:0][BYTE_W-1:0] bytes;
      logic [POS_W-1:0]                   len;
   } pat_type;

   typedef struct packed {
      logic empty;
      logic full;
   } front_stat_type;

   typedef struct packed {
      logic                 pop;
      logic                 pop_end;
      logic [PATTERN_MAX:0] active;
   } back_stat_type;

endpackage

// File: rtl/core/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Glob match ('*', '?') of a byte stream against a 32-byte pattern register.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, text bytes and end of text alike, while the queue has room.
// End of text goes through the queue entry written at acceptance, then the result
//   register that drives rsp_valid; a text byte goes through the queue, then the active set.
// The request queue holds 2 entries, so a stalled result slot backs up input.
// Reset (synchronous): pattern and length cleared, active set = start only.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
   import wpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [BYTE_W-1:0]    req_text_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_matched,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   pat_type        pat;
   op_type         head;
   logic           head_valid;
   logic           pop;
   front_stat_type front_stat;
   back_stat_type  back_stat;

   wpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pat       (pat)
   );

   wpm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_text_byte (req_text_byte),
      .pop           (pop),
      .head          (head),
      .head_valid    (head_valid),
      .stat          (front_stat)
   );

   wpm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pat         (pat),
      .head        (head),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_matched (rsp_matched),
      .stat        (back_stat)
   );

   // Back end only drains a queue that holds something
   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |-> !front_stat.empty)
      else $error("pop from empty request queue");

   // End of text returns the set to the start position
   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      back_stat.pop_end |=> (back_stat.active == START_SET))
      else $error("active set not restarted after end of text");

   // A new result only follows an end-of-text pop
   a_rsp_from_end : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_stat.pop_end))
      else $error("result raised without end of text");

endmodule

// File: rtl/core/wpm_csr.sv
// ----------------------------------------------------------------------------
// wpm_csr
// Pattern registers and their decode into per-position star, '?' and bytes.
// ----------------------------------------------------------------------------
module wpm_csr
   import wpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data,
   output pat_type              pat
);

   logic [WORD_W-1:0]   words_ff [WORD_COUNT];
   logic [LENGTH_W-1:0] length_ff;

   assign csr_ready = 1'b1;

   // Write the addressed register; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            words_ff[w] <= '0;
         end
         length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WORD_0: words_ff[0] <= csr_data;
            REG_WORD_1: words_ff[1] <= csr_data;
            REG_WORD_2: words_ff[2] <= csr_data;
            REG_WORD_3: words_ff[3] <= csr_data;
            REG_LENGTH: length_ff   <= csr_data[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Decode pattern bytes; bytes past the registers read as zero
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < PAT_BYTES) begin
            pat.bytes[i] = words_ff[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
         end else begin
            pat.bytes[i] = '0;
         end
         pat.star[i]  = (pat.bytes[i] == STAR);
         pat.qmark[i] = (pat.bytes[i] == QMARK);
      end
      // Saturate the length at the pattern size
      pat.len = (int'(length_ff) > PATTERN_MAX) ? POS_W'(PATTERN_MAX)
                                                : POS_W'(length_ff);
   end

endmodule

// File: rtl/core/wpm_front.sv
// ----------------------------------------------------------------------------
// wpm_front
// Request intake: classify each request and hold it in a short queue.
// ----------------------------------------------------------------------------
module wpm_front
   import wpm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_func,
   input  logic [BYTE_W-1:0] req_text_byte,
   input  logic           pop,
   output op_type         head,
   output logic           head_valid,
   output front_stat_type stat
);

   op_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                push;
   op_type              op;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign req_ready  = !stat.full;
   assign push       = req_valid && req_ready;
   assign head_valid = !stat.empty;
   assign head       = queue_ff[rd_ptr_ff];

   // Classify: end of text carries no byte
   always_comb begin
      op.func = func_type'(req_func);
      op.text = (op.func == FUNC_END) ? '0 : req_text_byte;
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= op;
      end
   end

endmodule

// File: rtl/core/wpm_back.sv
// ----------------------------------------------------------------------------
// wpm_back
// Active position set: star closure, per-byte advance, and result register.
// ----------------------------------------------------------------------------
module wpm_back
   import wpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pat_type       pat,
   input  op_type        head,
   input  logic          head_valid,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_matched,
   output back_stat_type stat
);

   logic [PATTERN_MAX:0]   active_ff, active_in;
   logic                   rsp_valid_ff;
   logic                   rsp_matched_ff;
   logic [PATTERN_MAX:0]   gen, prop, gen_old, prop_old;
   logic [PATTERN_MAX:0]   closed;
   logic [PATTERN_MAX-1:0] in_range, stay, adv;
   logic                   matched;
   logic                   is_end;

   assign is_end = (head.func == FUNC_END);

   // Take a byte at once; take end of text when the result slot frees up
   assign pop = head_valid && (!is_end || !rsp_valid_ff || rsp_ready);

   // Close the set over '*' with a parallel prefix (stars propagate upward)
   always_comb begin
      for (int j = 0; j <= PATTERN_MAX; j++) begin
         gen[j] = active_ff[j] && (j <= int'(pat.len));
         if (j == 0) begin
            prop[j] = 1'b0;
         end else begin
            prop[j] = pat.star[j-1] && ((j - 1) < int'(pat.len));
         end
      end
      for (int k = 0; k < PREFIX_LEVELS; k++) begin
         gen_old  = gen;
         prop_old = prop;
         for (int j = 0; j <= PATTERN_MAX; j++) begin
            if (j >= (1 << k)) begin
               gen[j]  = gen_old[j] | (prop_old[j] & gen_old[j - (1 << k)]);
               prop[j] = prop_old[j] & prop_old[j - (1 << k)];
            end
         end
      end
      closed = gen;
   end

   assign matched = closed[pat.len];

   // Advance every live position by one text byte
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         in_range[i] = (i < int'(pat.len));
         stay[i] = closed[i] && in_range[i] && pat.star[i];
         adv[i]  = closed[i] && in_range[i] && !pat.star[i]
                   && (pat.qmark[i] || (pat.bytes[i] == head.text));
      end
      active_in = {1'b0, stay} | {adv, 1'b0};
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= START_SET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            active_ff <= is_end ? START_SET : active_in;
         end
         if (pop && is_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_end) begin
         rsp_matched_ff <= matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   assign stat.pop     = pop;
   assign stat.pop_end = pop && is_end;
   assign stat.active  = active_ff;

endmodule

// File: bench/wpm_match_checker.sv
// ----------------------------------------------------------------------------
// wpm_match_checker
// Watches the register, request and result channels of the wildcard pattern
// matcher. Keeps its own copy of the pattern and of the set of reachable
// pattern positions, predicts the match bit of every end-of-text request and
// compares it with the result the block returns.
// ----------------------------------------------------------------------------
module wpm_match_checker
   import wpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_func,
   input  logic [BYTE_W-1:0]    req_text_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_matched,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data,
   output int                   failures,
   output int                   pending_results,
   output int                   results_seen,
   output int                   match_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow registers and reachable positions
   logic [WORD_W-1:0]    pattern_words [WORD_COUNT];
   logic [LENGTH_W-1:0]  pattern_len;
   logic [PATTERN_MAX:0] reach_set;
   logic                 expected_match_q [$];

   initial begin
      failures        = 0;
      pending_results = 0;
      results_seen    = 0;
      match_count     = 0;
   end

   task automatic report(input string what);
      $display("wpm_match_checker: %0t ns: %s", $time, what);
      failures++;
   endtask

   // Pattern byte at a position; bytes past the registers read as zero
   function automatic logic [BYTE_W-1:0] pattern_at(input int pos);
      if (pos >= PAT_BYTES) return '0;
      return pattern_words[pos / BYTES_PER_WORD][(pos % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
   endfunction

   // A star at a reachable position also reaches the next one
   function automatic logic [PATTERN_MAX:0] close_over_stars(input logic [PATTERN_MAX:0] set,
                                                             input int n);
      logic [PATTERN_MAX:0] grown;
      grown = set;
      for (int i = 0; i < n; i++) begin
         if (grown[i] && pattern_at(i) == STAR) grown[i + 1] = 1'b1;
      end
      return grown;
   endfunction

   always @(posedge clock) begin : track
      int                   n;
      logic [PATTERN_MAX:0] cur;
      logic [PATTERN_MAX:0] nxt;
      logic [BYTE_W-1:0]    p;
      logic                 want;

      if (reset) begin
         foreach (pattern_words[w]) pattern_words[w] = '0;
         pattern_len = '0;
         reach_set   = START_SET;
         expected_match_q.delete();
      end else begin
         // Compare the returned match bit with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_matched === 1'b1) match_count++;
            if (expected_match_q.size() == 0) begin
               report($sformatf("result with no end of text waiting (matched=%b)",
                                rsp_matched));
            end else begin
               want = expected_match_q.pop_front();
               if (rsp_matched !== want)
                  report($sformatf("matched is %b, predicted %b", rsp_matched, want));
            end
         end

         // Track register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_LENGTH) pattern_len = csr_data[LENGTH_W-1:0];
            else if (csr_index < WORD_COUNT) pattern_words[csr_index] = csr_data;
         end

         // Advance the reachable positions for each accepted request
         if (req_valid && req_ready) begin
            n   = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
            cur = reach_set;
            for (int i = n + 1; i <= PATTERN_MAX; i++) cur[i] = 1'b0;
            cur = close_over_stars(cur, n);
            if (req_func == FUNC_END) begin
               expected_match_q.push_back(cur[n]);
               reach_set = START_SET;
            end else begin
               nxt = '0;
               for (int i = 0; i < n; i++) begin
                  if (cur[i]) begin
                     p = pattern_at(i);
                     if (p == STAR) nxt[i] = 1'b1;
                     else if (p == QMARK || p == req_text_byte) nxt[i + 1] = 1'b1;
                  end
               end
               reach_set = nxt;
            end
         end
      end
      pending_results <= expected_match_q.size();
   end

endmodule

// File: bench/tb_wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// tb_wildcard_pattern_matcher
// Drives glob patterns into the registers and streams texts through the
// matcher: a directed set of corner cases, then random patterns with texts
// mostly built to match them, under random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_wildcard_pattern_matcher
   import wpm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_MAX       = 17;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT    = 1000;
   localparam int RANDOM_ITEMS  = 800;

   localparam logic [CSR_IDX_W-1:0] WORD_REGS [WORD_COUNT] =
      '{REG_WORD_0, REG_WORD_1, REG_WORD_2, REG_WORD_3};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_func;
   logic [BYTE_W-1:0]    req_text_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_matched;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;

   int failures;
   int pending_results;
   int results_seen;
   int match_count;
   int items_sent     = 0;
   int csr_writes     = 0;
   int settings_tried = 0;
   int idle_cycles    = 0;
   bit calm           = 1'b0;

   // Pattern as last written, and the text being built
   logic [BYTE_W-1:0] pat_bytes [PAT_BYTES];
   int                pat_len = 0;
   logic [BYTE_W-1:0] text_q [$];

   wildcard_pattern_matcher dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_matched   (rsp_matched),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   wpm_match_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_matched     (rsp_matched),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (failures),
      .pending_results (pending_results),
      .results_seen    (results_seen),
      .match_count     (match_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort when no channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending_results);
         $display("tb_wildcard_pattern_matcher: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: stall a random number of cycles before each result
   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = calm ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Hold valid until accepted; leave it high so the next request can follow
   task automatic send_request(input func_type f, input logic [BYTE_W-1:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(input bit finish);
      foreach (text_q[i]) send_request(FUNC_BYTE, text_q[i]);
      if (finish) send_request(FUNC_END, BYTE_W'($urandom));
   endtask

   task automatic send_string(input string s, input bit finish);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_text(finish);
   endtask

   // Drop valid and wait until every result is back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   // Write the pattern words (optionally) and the length, junk in upper bits
   task automatic load_pattern(input bit with_words);
      logic [WORD_W-1:0] word;
      if (with_words) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            for (int b = 0; b < BYTES_PER_WORD; b++)
               word[b * BYTE_W +: BYTE_W] = pat_bytes[w * BYTES_PER_WORD + b];
            write_register(WORD_REGS[w], word);
         end
      end
      word = {$urandom, $urandom};
      word[LENGTH_W-1:0] = LENGTH_W'(pat_len);
      write_register(REG_LENGTH, word);
      csr_valid <= 1'b0;
      settings_tried++;
   endtask

   task automatic set_pattern_string(input string s, input int length_value);
      for (int i = 0; i < PAT_BYTES; i++) pat_bytes[i] = (i < s.len()) ? s[i] : '0;
      pat_len = length_value;
      load_pattern(1'b1);
   endtask

   // Small alphabet so that literals collide often, with some full-range bytes
   function automatic logic [BYTE_W-1:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return "a";
      if (r < 6) return "b";
      if (r < 7) return "c";
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [BYTE_W-1:0] pick_pattern_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return "a";
      if (r < 5) return "b";
      if (r < 7) return STAR;
      if (r < 8) return QMARK;
      if (r < 9) return "c";
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic build_pattern();
      if ($urandom_range(0, 9) == 0) begin
         for (int i = 0; i < PAT_BYTES; i++) pat_bytes[i] = BYTE_W'($urandom_range(0, 255));
         pat_len = $urandom_range(0, 63);
      end else begin
         for (int i = 0; i < PAT_BYTES; i++) pat_bytes[i] = pick_pattern_byte();
         pat_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, PATTERN_MAX)
                                               : $urandom_range(0, 8);
         if (pat_len == PATTERN_MAX && $urandom_range(0, 1) == 1)
            pat_len = $urandom_range(PATTERN_MAX + 1, 63);
      end
   endtask

   // Mostly texts expanded from the pattern, some mutated, some pure noise
   task automatic make_text();
      int n;
      int mode;
      int pos;
      text_q.delete();
      n    = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
      mode = $urandom_range(0, 9);
      if (mode < 8) begin
         for (int i = 0; i < n; i++) begin
            if (pat_bytes[i] == STAR) begin
               repeat ($urandom_range(0, 3)) text_q.push_back(pick_text_byte());
            end else if (pat_bytes[i] == QMARK) begin
               text_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
               text_q.push_back(pat_bytes[i]);
            end
         end
         if (mode >= 6) begin
            pos = (text_q.size() > 0) ? $urandom_range(0, text_q.size() - 1) : 0;
            case ($urandom_range(0, 2))
               0: begin
                  if (text_q.size() > 0) text_q[pos] = pick_text_byte();
               end
               1: begin
                  if (text_q.size() > 0) text_q.delete(pos);
               end
               default: begin
                  text_q.insert(pos, pick_text_byte());
               end
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 10)) text_q.push_back(pick_text_byte());
      end
   endtask

   initial begin : stimulus
      int start_items;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_BYTE;
      req_text_byte = '0;
      csr_valid     = 1'b0;
      csr_index     = REG_WORD_0;
      csr_data      = '0;
      foreach (pat_bytes[i]) pat_bytes[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern straight from reset: only the empty text matches
      send_request(FUNC_END, 8'h00);
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_END, 8'hFF);
      settle();

      // Literal, single wildcard and star together
      set_pattern_string("a?*b", 4);
      send_string("axb", 1'b1);
      send_string("ab", 1'b1);
      settle();

      // Full pattern of stars ending in a zero byte, length saturating
      for (int i = 0; i < PAT_BYTES - 1; i++) pat_bytes[i] = STAR;
      pat_bytes[PAT_BYTES - 1] = 8'h00;
      pat_len = 63;
      load_pattern(1'b1);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_END, 8'h00);
      send_request(FUNC_BYTE, 8'h01);
      send_request(FUNC_END, 8'h00);
      settle();

      // Shorten the pattern in the middle of a text: far positions drop out
      set_pattern_string("abc", 3);
      send_string("ab", 1'b0);
      settle();
      pat_len = 1;
      load_pattern(1'b0);
      send_request(FUNC_END, 8'h5A);
      send_string("a", 1'b1);
      send_string("ab", 1'b1);
      settle();

      // Wildcard against the top byte value after a leading star
      set_pattern_string("*?", 2);
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_END, 8'hFF);
      settle();

      // Random patterns, each followed by a burst of texts
      start_items = items_sent;
      while (items_sent < start_items + RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         if (items_sent > start_items && $urandom_range(0, 4) == 0) begin
            pat_len = $urandom_range(0, 63);
            load_pattern(1'b0);
         end else begin
            build_pattern();
            load_pattern(1'b1);
         end
         repeat ($urandom_range(1, 6)) begin
            make_text();
            send_text(1'b1);
            if ($urandom_range(0, 15) == 0) settle();
         end
         // Sometimes leave a text open across the next pattern change
         if ($urandom_range(0, 7) == 0) begin
            make_text();
            send_text(1'b0);
         end
         settle();
      end

      calm = 1'b0;
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d requests, %0d results checked (%0d matches)",
               items_sent, results_seen, match_count);
      $display("summary: %0d register writes over %0d pattern settings",
               csr_writes, settings_tried);
      if (failures == 0 && pending_results == 0) begin
         $display("tb_wildcard_pattern_matcher: PASS");
      end else begin
         $display("tb_wildcard_pattern_matcher: FAIL");
      end
      $finish;
   end

endmodule
